>>> hdl/rad_pkg.sv
package rad_pkg;

    localparam int NPROC = 4;
    localparam int NRES  = 3;
    localparam int UW    = 4;
    localparam int PW    = 2;
    // work vector must hold free plus every holding without wrapping
    localparam int WW    = UW + 3;
    localparam int CW    = 2;

    localparam logic [UW-1:0] UMAX        = {UW{1'b1}};
    localparam logic [UW-1:0] RESET_TOTAL = UW'(4);

    localparam logic [CW-1:0] CFG_TOTAL_A = CW'(0);
    localparam logic [CW-1:0] CFG_TOTAL_B = CW'(1);
    localparam logic [CW-1:0] CFG_TOTAL_C = CW'(2);

    typedef enum logic [1:0] {
        OP_REQ = 2'd0,
        OP_REL = 2'd1,
        OP_FIN = 2'd2,
        OP_DET = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        EV_GRANT   = 3'd0,
        EV_BLOCK   = 3'd1,
        EV_REFUSED = 3'd2,
        EV_RELEASE = 3'd3,
        EV_FINISH  = 3'd4,
        EV_NO_DL   = 3'd5,
        EV_KILL    = 3'd6,
        EV_UNBLOCK = 3'd7
    } ev_t;

    typedef logic [UW-1:0] unit_t;
    typedef unit_t [NRES-1:0] uvec_t;

    typedef struct packed {
        op_t            op;
        logic [PW-1:0]  pid;
        uvec_t          want;
    } cmd_t;

    typedef struct packed {
        ev_t            kind;
        logic [PW-1:0]  pid;
        uvec_t          free;
    } res_t;

    typedef struct packed {
        logic busy;
        logic hold_valid;
    } bk_stat_t;

    function automatic unit_t sat_add(unit_t a, unit_t b);
        logic [UW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[UW] ? UMAX : s[UW-1:0];
    endfunction

    function automatic logic fits(uvec_t want, uvec_t avail);
        logic ok;
        ok = 1'b1;
        for (int j = 0; j < NRES; j++)
        begin
            if (want[j] > avail[j])
                ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

>>> hdl/rad_if.sv
interface rad_in_if;
    import rad_pkg::*;
    logic          valid;
    logic          ready;
    logic [1:0]    opcode;
    logic [PW-1:0] proc_id;
    logic [UW-1:0] want_a;
    logic [UW-1:0] want_b;
    logic [UW-1:0] want_c;
    modport source (output valid, opcode, proc_id, want_a, want_b, want_c, input ready);
    modport sink   (input valid, opcode, proc_id, want_a, want_b, want_c, output ready);
endinterface

interface rad_out_if;
    import rad_pkg::*;
    logic          valid;
    logic          ready;
    logic [2:0]    event_kind;
    logic [PW-1:0] proc_out;
    logic [UW-1:0] free_a;
    logic [UW-1:0] free_b;
    logic [UW-1:0] free_c;
    logic          last_result;
    modport source (output valid, event_kind, proc_out, free_a, free_b, free_c, last_result,
                    input ready);
    modport sink   (input valid, event_kind, proc_out, free_a, free_b, free_c, last_result,
                    output ready);
endinterface

interface rad_cfg_if;
    import rad_pkg::*;
    logic          valid;
    logic          ready;
    logic [CW-1:0] index;
    logic [UW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/rad_front.sv
module rad_front (
    input  logic          clk,
    input  logic          rst_n,
    rad_in_if.sink        in_ch,
    output rad_pkg::cmd_t q_cmd,
    output logic          q_valid,
    input  logic          q_pop
);
    import rad_pkg::*;

    cmd_t       q_mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    cmd_t       in_cmd;

    // decode the transfer into a command
    always_comb
    begin
        in_cmd.op      = op_t'(in_ch.opcode);
        in_cmd.pid     = in_ch.proc_id;
        in_cmd.want[0] = in_ch.want_a;
        in_cmd.want[1] = in_ch.want_b;
        in_cmd.want[2] = in_ch.want_c;
    end

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != 2'd0);
    assign q_cmd       = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= in_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !q_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (!push && q_pop)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

>>> hdl/rad_back.sv
module rad_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rad_pkg::cmd_t     q_cmd,
    input  logic              q_valid,
    output logic              q_pop,
    rad_cfg_if.sink           cfg,
    rad_out_if.source         out_ch,
    output rad_pkg::bk_stat_t stat
);
    import rad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_D_INIT, S_D_SCAN, S_D_EVAL, S_D_PICK, S_D_UNBLK, S_FLUSH
    } state_t;

    state_t                   state_reg;
    cmd_t                     cmd_reg;
    uvec_t                    free_reg;
    uvec_t                    held_reg    [NPROC];
    uvec_t                    pending_reg [NPROC];
    logic [NPROC-1:0]         term_reg;
    logic [NPROC-1:0]         blk_reg;
    logic [NPROC-1:0]         done_reg;
    logic [NRES-1:0][WW-1:0]  work_reg;
    logic [PW-1:0]            idx_reg;
    logic                     found_reg;
    res_t                     hold_reg;
    logic                     hold_valid_reg;
    res_t                     out_res_reg;
    logic                     out_last_reg;
    logic                     out_valid_reg;

    logic                     slot_free;
    logic                     can_emit;
    logic                     out_load;
    logic                     ev_go;
    res_t                     ev_res;
    logic [PW-1:0]            p;
    logic                     req_fit;
    uvec_t                    grant_free;
    uvec_t                    rel_free;
    uvec_t                    kill_free;
    uvec_t                    ub_free;
    logic                     ub_cand;
    logic                     sc_ok;
    logic [NPROC-1:0]         holds;
    logic [UW+1:0]            tot [NPROC];
    logic [PW-1:0]            vic;
    logic [UW+1:0]            best;
    logic                     vfound;
    logic [NPROC-1:0]         done_after;
    logic                     last_idx;

    assign p         = cmd_reg.pid;
    assign slot_free = !out_valid_reg || out_ch.ready;
    assign can_emit  = !hold_valid_reg || slot_free;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign last_idx  = (idx_reg == PW'(NPROC - 1));
    assign cfg.ready = 1'b1;
    // the held result moves into the output register this cycle
    assign out_load  = hold_valid_reg && (ev_go || ((state_reg == S_FLUSH) && slot_free));

    always_comb
    begin
        req_fit = fits(cmd_reg.want, free_reg);
        ub_cand = blk_reg[idx_reg] && !term_reg[idx_reg]
                  && fits(pending_reg[idx_reg], free_reg);
        sc_ok   = !done_reg[idx_reg];
        for (int j = 0; j < NRES; j++)
        begin
            grant_free[j] = free_reg[j] - cmd_reg.want[j];
            rel_free[j]   = sat_add(free_reg[j], held_reg[p][j]);
            ub_free[j]    = free_reg[j] - pending_reg[idx_reg][j];
            if (WW'(pending_reg[idx_reg][j]) > work_reg[j])
                sc_ok = 1'b0;
        end
        for (int i = 0; i < NPROC; i++)
        begin
            holds[i] = |held_reg[i];
            tot[i]   = '0;
            for (int j = 0; j < NRES; j++)
                tot[i] = tot[i] + (UW+2)'(held_reg[i][j]);
        end
        // smallest holding among the deadlocked, lowest index on ties
        vic    = '0;
        best   = '0;
        vfound = 1'b0;
        for (int i = 0; i < NPROC; i++)
        begin
            if (!done_reg[i] && (!vfound || tot[i] < best))
            begin
                vic    = PW'(i);
                best   = tot[i];
                vfound = 1'b1;
            end
        end
        for (int j = 0; j < NRES; j++)
            kill_free[j] = sat_add(free_reg[j], held_reg[vic][j]);
        done_after      = done_reg;
        done_after[vic] = 1'b1;
    end

    // result produced in this cycle
    always_comb
    begin
        ev_go       = 1'b0;
        ev_res.kind = EV_NO_DL;
        ev_res.pid  = p;
        ev_res.free = free_reg;
        case (state_reg)
            S_EXEC:
            begin
                ev_go = can_emit;
                case (cmd_reg.op)
                    OP_REQ:
                    begin
                        if (term_reg[p])
                            ev_res.kind = EV_REFUSED;
                        else if (req_fit)
                        begin
                            ev_res.kind = EV_GRANT;
                            ev_res.free = grant_free;
                        end
                        else
                            ev_res.kind = EV_BLOCK;
                    end
                    OP_REL:
                    begin
                        if (term_reg[p])
                            ev_res.kind = EV_REFUSED;
                        else
                        begin
                            ev_res.kind = EV_RELEASE;
                            ev_res.free = rel_free;
                        end
                    end
                    default: ev_res.kind = EV_FINISH;
                endcase
            end
            S_D_EVAL:
            begin
                ev_go      = (&done_reg) && can_emit;
                ev_res.pid = '0;
            end
            S_D_PICK:
            begin
                ev_go       = can_emit;
                ev_res.kind = EV_KILL;
                ev_res.pid  = vic;
                ev_res.free = kill_free;
            end
            S_D_UNBLK:
            begin
                ev_go       = ub_cand && can_emit;
                ev_res.kind = EV_UNBLOCK;
                ev_res.pid  = idx_reg;
                ev_res.free = ub_free;
            end
            default: ev_go = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            free_reg       <= {NRES{RESET_TOTAL}};
            for (int i = 0; i < NPROC; i++)
            begin
                held_reg[i]    <= '0;
                pending_reg[i] <= '0;
            end
            term_reg       <= '0;
            blk_reg        <= '0;
            done_reg       <= '0;
            work_reg       <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            hold_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_res_reg    <= '0;
            out_last_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_ch.ready && !out_load)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_cmd;
                        state_reg <= (q_cmd.op == OP_DET) ? S_D_INIT : S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (can_emit)
                    begin
                        case (cmd_reg.op)
                            OP_REQ:
                            begin
                                if (!term_reg[p] && req_fit)
                                begin
                                    free_reg <= grant_free;
                                    for (int j = 0; j < NRES; j++)
                                        held_reg[p][j] <= sat_add(held_reg[p][j],
                                                                  cmd_reg.want[j]);
                                    pending_reg[p] <= '0;
                                    blk_reg[p]     <= 1'b0;
                                end
                                else if (!term_reg[p])
                                begin
                                    pending_reg[p] <= cmd_reg.want;
                                    blk_reg[p]     <= 1'b1;
                                end
                            end
                            OP_REL:
                            begin
                                if (!term_reg[p])
                                begin
                                    free_reg    <= rel_free;
                                    held_reg[p] <= '0;
                                end
                            end
                            default: term_reg[p] <= 1'b1;
                        endcase
                        state_reg <= S_FLUSH;
                    end
                end
                S_D_INIT:
                begin
                    for (int j = 0; j < NRES; j++)
                        work_reg[j] <= WW'(free_reg[j]);
                    done_reg  <= term_reg | ~holds;
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    state_reg <= S_D_SCAN;
                end
                S_D_SCAN:
                begin
                    if (sc_ok)
                    begin
                        for (int j = 0; j < NRES; j++)
                            work_reg[j] <= work_reg[j] + WW'(held_reg[idx_reg][j]);
                        done_reg[idx_reg] <= 1'b1;
                    end
                    if (last_idx)
                    begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        if (!(found_reg || sc_ok))
                            state_reg <= S_D_EVAL;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + PW'(1);
                        found_reg <= found_reg || sc_ok;
                    end
                end
                S_D_EVAL:
                begin
                    if (!(&done_reg))
                        state_reg <= S_D_PICK;
                    else if (can_emit)
                        state_reg <= S_FLUSH;
                end
                S_D_PICK:
                begin
                    if (can_emit)
                    begin
                        free_reg         <= kill_free;
                        held_reg[vic]    <= '0;
                        pending_reg[vic] <= '0;
                        term_reg[vic]    <= 1'b1;
                        blk_reg[vic]     <= 1'b0;
                        done_reg[vic]    <= 1'b1;
                        if (&done_after)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_D_UNBLK;
                        end
                    end
                end
                S_D_UNBLK:
                begin
                    if (!ub_cand || can_emit)
                    begin
                        if (ub_cand)
                        begin
                            free_reg <= ub_free;
                            for (int j = 0; j < NRES; j++)
                                held_reg[idx_reg][j] <= sat_add(held_reg[idx_reg][j],
                                                                pending_reg[idx_reg][j]);
                            pending_reg[idx_reg] <= '0;
                            blk_reg[idx_reg]     <= 1'b0;
                        end
                        if (last_idx)
                            state_reg <= S_FLUSH;
                        else
                            idx_reg <= idx_reg + PW'(1);
                    end
                end
                S_FLUSH:
                begin
                    if (!hold_valid_reg)
                        state_reg <= S_IDLE;
                    else if (slot_free)
                    begin
                        out_res_reg    <= hold_reg;
                        out_last_reg   <= 1'b1;
                        out_valid_reg  <= 1'b1;
                        hold_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase

            // a new result pushes the held one out as a non-final transfer
            if (ev_go)
            begin
                if (hold_valid_reg)
                begin
                    out_res_reg   <= hold_reg;
                    out_last_reg  <= 1'b0;
                    out_valid_reg <= 1'b1;
                end
                hold_reg       <= ev_res;
                hold_valid_reg <= 1'b1;
            end

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_TOTAL_A: free_reg[0] <= cfg.data;
                    CFG_TOTAL_B: free_reg[1] <= cfg.data;
                    CFG_TOTAL_C: free_reg[2] <= cfg.data;
                    default:     ;
                endcase
            end
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.event_kind  = out_res_reg.kind;
    assign out_ch.proc_out    = out_res_reg.pid;
    assign out_ch.free_a      = out_res_reg.free[0];
    assign out_ch.free_b      = out_res_reg.free[1];
    assign out_ch.free_c      = out_res_reg.free[2];
    assign out_ch.last_result = out_last_reg;

    assign stat.busy       = (state_reg != S_IDLE);
    assign stat.hold_valid = hold_valid_reg;

endmodule

>>> hdl/resource_allocator_deadlock_detect.sv
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   opcode, proc_id, want_a, want_b, want_c
// out_ch    out  valid/ready   event_kind, proc_out, free_a..c, last_result
// cfg       in   valid/ready   index (total_units_a/b/c), data
//
// Request, release and finish go from transfer to result through the queue,
// dispatch, execute and a final flush through the output register.
// Detect runs the work/finish scan, which visits one process per cycle for
// at most NPROC+1 passes, then kills the victims one at a time and sweeps
// every process to unblock. Reset is asynchronous, active low; free
// counts return to 4. A stalled output holds the back end; the 2-entry queue
// keeps accepting transfers until full.
module resource_allocator_deadlock_detect (
    input  logic clk,
    input  logic rst_n,
    rad_in_if.sink    in_ch,
    rad_out_if.source out_ch,
    rad_cfg_if.sink   cfg
);
    import rad_pkg::*;

    cmd_t     q_cmd;
    logic     q_valid;
    logic     q_pop;
    bk_stat_t bk_stat;

    // front end: accept, decode and queue commands
    rad_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_cmd   (q_cmd),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    // back end: allocator state, detection sequencer and result staging
    rad_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_cmd   (q_cmd),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .cfg     (cfg),
        .out_ch  (out_ch),
        .stat    (bk_stat)
    );

`ifndef SYNTHESIS
    // never pop an empty queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // a non-final transfer means more results of this item are still in work
    a_more_results: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && !out_ch.last_result) |-> bk_stat.busy)
        else $error("non-final result with back end idle");

    // a staged result never outlives its item
    a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.hold_valid |-> bk_stat.busy)
        else $error("staged result left behind in idle");
`endif

endmodule

>>> dv/rad_tb_if.sv
interface rad_tb_probe;
    import rad_pkg::*;
    logic [31:0] fail_count;
    logic [31:0] outstanding;
endinterface

>>> dv/rad_checker.sv
module rad_checker (
    input  logic clk,
    input  logic rst_n,
    rad_in_if.sink    in_mon,
    rad_out_if.sink   out_mon,
    rad_cfg_if.sink   cfg_mon,
    output int        fail_count,
    output int        results_pending,
    output int        results_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import rad_pkg::*;

    typedef struct packed {
        ev_t           kind;
        logic [PW-1:0] pid;
        uvec_t         free;
        logic          last;
    } alloc_event_t;

    uvec_t free_cnt;
    uvec_t held  [NPROC];
    uvec_t pend  [NPROC];
    logic  term  [NPROC];
    logic  blk   [NPROC];
    alloc_event_t expected_events[$];

    function automatic unit_t add_sat(unit_t a, unit_t b);
        logic [UW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[UW] ? UMAX : s[UW-1:0];
    endfunction

    function automatic logic want_fits(uvec_t w);
        logic ok;
        ok = 1'b1;
        for (int j = 0; j < NRES; j++)
        begin
            if (w[j] > free_cnt[j])
                ok = 1'b0;
        end
        return ok;
    endfunction

    task automatic push_event(ev_t k, int p);
        alloc_event_t e;
        e.kind = k;
        e.pid  = PW'(p);
        e.free = free_cnt;
        e.last = 1'b0;
        expected_events.push_back(e);
    endtask

    task automatic grant_units(int p, uvec_t w);
        for (int j = 0; j < NRES; j++)
        begin
            free_cnt[j] = free_cnt[j] - w[j];
            held[p][j]  = add_sat(held[p][j], w[j]);
            pend[p][j]  = '0;
        end
        blk[p] = 1'b0;
    endtask

    task automatic run_detection();
        logic [WW-1:0] work [NRES];
        logic done [NPROC];
        logic dead [NPROC];
        logic progress, ok, holds;
        int   ndead, victim, best, s;
        for (int j = 0; j < NRES; j++)
            work[j] = WW'(free_cnt[j]);
        ndead = 0;
        for (int i = 0; i < NPROC; i++)
        begin
            holds = 1'b0;
            for (int j = 0; j < NRES; j++)
                if (held[i][j] != 0)
                    holds = 1'b1;
            done[i] = term[i] || !holds;
        end
        do
        begin
            progress = 1'b0;
            for (int i = 0; i < NPROC; i++)
            begin
                if (!done[i])
                begin
                    ok = 1'b1;
                    for (int j = 0; j < NRES; j++)
                        if (WW'(pend[i][j]) > work[j])
                            ok = 1'b0;
                    if (ok)
                    begin
                        for (int j = 0; j < NRES; j++)
                            work[j] = work[j] + WW'(held[i][j]);
                        done[i]  = 1'b1;
                        progress = 1'b1;
                    end
                end
            end
        end while (progress);
        for (int i = 0; i < NPROC; i++)
        begin
            dead[i] = !done[i];
            if (dead[i])
                ndead++;
        end
        if (ndead == 0)
        begin
            push_event(EV_NO_DL, 0);
            return;
        end
        // kill the smallest holder first, lowest index on a tie
        repeat (ndead)
        begin
            victim = -1;
            best = 0;
            for (int i = 0; i < NPROC; i++)
            begin
                if (dead[i])
                begin
                    s = 0;
                    for (int j = 0; j < NRES; j++)
                        s += held[i][j];
                    if (victim < 0 || s < best)
                    begin
                        best = s;
                        victim = i;
                    end
                end
            end
            for (int j = 0; j < NRES; j++)
            begin
                free_cnt[j] = add_sat(free_cnt[j], held[victim][j]);
                held[victim][j] = '0;
                pend[victim][j] = '0;
            end
            term[victim] = 1'b1;
            blk[victim]  = 1'b0;
            dead[victim] = 1'b0;
            push_event(EV_KILL, victim);
        end
        for (int i = 0; i < NPROC; i++)
        begin
            if (blk[i] && !term[i] && want_fits(pend[i]))
            begin
                grant_units(i, pend[i]);
                push_event(EV_UNBLOCK, i);
            end
        end
    endtask

    task automatic predict_events(op_t op, int p, uvec_t w);
        int before_n;
        before_n = expected_events.size();
        if (op == OP_DET)
            run_detection();
        else if (op == OP_REQ)
        begin
            if (term[p])
                push_event(EV_REFUSED, p);
            else if (want_fits(w))
            begin
                grant_units(p, w);
                push_event(EV_GRANT, p);
            end
            else
            begin
                pend[p] = w;
                blk[p]  = 1'b1;
                push_event(EV_BLOCK, p);
            end
        end
        else if (op == OP_REL)
        begin
            if (term[p])
                push_event(EV_REFUSED, p);
            else
            begin
                for (int j = 0; j < NRES; j++)
                begin
                    free_cnt[j] = add_sat(free_cnt[j], held[p][j]);
                    held[p][j]  = '0;
                end
                push_event(EV_RELEASE, p);
            end
        end
        else
        begin
            term[p] = 1'b1;
            push_event(EV_FINISH, p);
        end
        if (expected_events.size() > before_n)
            expected_events[expected_events.size()-1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        alloc_event_t e;
        uvec_t w;
        if (!rst_n)
        begin
            free_cnt = {NRES{RESET_TOTAL}};
            for (int i = 0; i < NPROC; i++)
            begin
                held[i] = '0;
                pend[i] = '0;
                term[i] = 1'b0;
                blk[i]  = 1'b0;
            end
            expected_events.delete();
            fail_count = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                if (cfg_mon.index == CFG_TOTAL_A)
                    free_cnt[0] = cfg_mon.data;
                else if (cfg_mon.index == CFG_TOTAL_B)
                    free_cnt[1] = cfg_mon.data;
                else if (cfg_mon.index == CFG_TOTAL_C)
                    free_cnt[2] = cfg_mon.data;
            end
            // compare the result first: it was produced by older transfers
            if (out_mon.valid && out_mon.ready)
            begin
                results_seen++;
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d pid=%0d", $time,
                             out_mon.event_kind, out_mon.proc_out);
                    fail_count++;
                end
                else
                begin
                    e = expected_events.pop_front();
                    if (out_mon.event_kind != e.kind || out_mon.proc_out != e.pid ||
                        out_mon.free_a != e.free[0] || out_mon.free_b != e.free[1] ||
                        out_mon.free_c != e.free[2] || out_mon.last_result != e.last)
                    begin
                        $display("%0t: mismatch expected kind=%0d pid=%0d free=%0d/%0d/%0d last=%0b",
                                 $time, e.kind, e.pid, e.free[0], e.free[1], e.free[2], e.last);
                        $display("%0t:          actual   kind=%0d pid=%0d free=%0d/%0d/%0d last=%0b",
                                 $time, out_mon.event_kind, out_mon.proc_out, out_mon.free_a,
                                 out_mon.free_b, out_mon.free_c, out_mon.last_result);
                        fail_count++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                w[0] = in_mon.want_a;
                w[1] = in_mon.want_b;
                w[2] = in_mon.want_c;
                predict_events(op_t'(in_mon.opcode), int'(in_mon.proc_id), w);
            end
        end
        results_pending = expected_events.size();
    end
endmodule

>>> dv/resource_allocator_deadlock_detect_tb.sv
module resource_allocator_deadlock_detect_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rad_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    // idle margin after the last result comes back, before totals are retuned
    localparam int DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   results_pending;
    int   results_seen;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   transfers_sent;

    rad_in_if  in_ch();
    rad_out_if out_ch();
    rad_cfg_if cfg();
    rad_tb_probe probe();

    assign probe.fail_count  = 32'(fail_count);
    assign probe.outstanding = 32'(results_pending);

    resource_allocator_deadlock_detect dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    rad_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_mon          (in_ch.sink),
        .out_mon         (out_ch.sink),
        .cfg_mon         (cfg.sink),
        .fail_count      (fail_count),
        .results_pending (results_pending),
        .results_seen    (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout watchdog: count cycles and bail out if the run hangs.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("** resource_allocator_deadlock_detect: FAILED **");
                $finish;
            end
        end
    end

    // Receiver: drop ready at random by the current idle percentage.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Drive one transfer on the input channel, idling first at random.
    // Valid stays up after the transfer until the next call or a drain.
    task automatic send_cmd(op_t op, int p, int a, int b, int c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.opcode  <= op;
        in_ch.proc_id <= PW'(p);
        in_ch.want_a  <= UW'(a);
        in_ch.want_b  <= UW'(b);
        in_ch.want_c  <= UW'(c);
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        transfers_sent++;
        @(negedge clk);
    endtask

    // Hold off the sender until every expected result has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (probe.outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_total(logic [CW-1:0] idx, int val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= UW'(val);
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_totals(int a, int b, int c);
        write_total(CFG_TOTAL_A, a);
        write_total(CFG_TOTAL_B, b);
        write_total(CFG_TOTAL_C, c);
        cfg.valid <= 1'b0;
    endtask

    // Random traffic: mostly small requests that build contention, then
    // a detect now and then so deadlocks actually form and get broken.
    task automatic random_phase(int n);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 50)
                send_cmd(OP_REQ, $urandom_range(3), $urandom_range(3),
                         $urandom_range(3), $urandom_range(3));
            else if (r < 58)
                send_cmd(OP_REQ, $urandom_range(3), $urandom_range(15),
                         $urandom_range(15), $urandom_range(15));
            else if (r < 72)
                send_cmd(OP_REL, $urandom_range(3), $urandom_range(15),
                         $urandom_range(15), $urandom_range(15));
            else if (r < 77)
                send_cmd(OP_FIN, $urandom_range(3), $urandom_range(15),
                         $urandom_range(15), $urandom_range(15));
            else
                send_cmd(OP_DET, $urandom_range(3), $urandom_range(15),
                         $urandom_range(15), $urandom_range(15));
        end
    endtask

    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.opcode  = OP_REQ;
        in_ch.proc_id = '0;
        in_ch.want_a  = '0;
        in_ch.want_b  = '0;
        in_ch.want_c  = '0;
        cfg.valid     = 1'b0;
        cfg.index     = CFG_TOTAL_A;
        cfg.data      = '0;
        send_idle_pct = 20;
        recv_idle_pct = 88;
        transfers_sent = 0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: grant, block, detect with a two-way deadlock.
        send_cmd(OP_REQ, 0, 2, 2, 0);
        send_cmd(OP_REQ, 1, 2, 2, 4);
        send_cmd(OP_REQ, 0, 1, 0, 0);   // blocked on A
        send_cmd(OP_REQ, 1, 0, 1, 0);   // blocked on B: deadlock
        send_cmd(OP_DET, 2, 0, 0, 0);   // kill 0, unblock 1
        send_cmd(OP_REQ, 0, 0, 0, 0);   // refused, terminated
        send_cmd(OP_REL, 0, 0, 0, 0);   // refused release
        send_cmd(OP_REL, 1, 0, 0, 0);
        send_cmd(OP_DET, 3, 15, 15, 15); // nothing held: no deadlock
        // blocked process issues a new request that is granted and clears the pending one
        send_cmd(OP_REQ, 2, 15, 15, 15);
        send_cmd(OP_REQ, 2, 1, 1, 1);
        send_cmd(OP_REQ, 3, 3, 3, 3);   // granted
        send_cmd(OP_REL, 3, 0, 0, 0);   // release of the granted units
        send_cmd(OP_FIN, 2, 0, 0, 0);   // finish keeps holdings
        send_cmd(OP_DET, 0, 0, 0, 0);
        drain();

        // Max totals; finished process 2 is refused and the detect finds no deadlock.
        set_totals(15, 15, 15);
        send_cmd(OP_REQ, 3, 15, 15, 15);
        send_cmd(OP_REL, 3, 0, 0, 0);
        send_cmd(OP_REQ, 1, 5, 0, 0);
        send_cmd(OP_REQ, 2, 0, 5, 0);
        send_cmd(OP_REQ, 3, 0, 0, 5);
        send_cmd(OP_REQ, 1, 0, 11, 0);
        send_cmd(OP_REQ, 2, 0, 0, 11);
        send_cmd(OP_REQ, 3, 11, 0, 0);
        send_cmd(OP_DET, 1, 0, 0, 0);
        drain();

        // Zero totals: every nonzero request blocks.
        set_totals(0, 0, 0);
        send_cmd(OP_REQ, 3, 0, 0, 0);
        send_cmd(OP_REQ, 3, 1, 0, 0);
        send_cmd(OP_DET, 0, 0, 0, 0);
        drain();

        set_totals(6, 5, 7);
        random_phase(36);
        drain();                         // sender pauses until all results arrive

        send_idle_pct = 88;
        recv_idle_pct = 20;
        set_totals(3, 9, 4);
        random_phase(36);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_totals($urandom_range(15), $urandom_range(15), $urandom_range(15));
        random_phase(36);
        drain();

        $display("Sent %0d transfers, checked %0d results over six total settings,",
                 transfers_sent, results_seen);
        $display("including deadlock recovery, refusals and idle/stall mixes.");
        if (probe.fail_count == 0)
            $display("** resource_allocator_deadlock_detect: PASSED **");
        else
            $display("** resource_allocator_deadlock_detect: FAILED **");
        $finish;
    end
endmodule

>>> resource_allocator_deadlock_detect.f
hdl/rad_pkg.sv
hdl/rad_if.sv
hdl/rad_front.sv
hdl/rad_back.sv
hdl/resource_allocator_deadlock_detect.sv
dv/rad_tb_if.sv
dv/rad_checker.sv
dv/resource_allocator_deadlock_detect_tb.sv
